### sv/lcs_pkg.sv
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared types and constants of the LRU slot cache with request statistics.
// ----------------------------------------------------------------------------
package lcs_pkg;

    localparam int KEY_W      = 32;
    localparam int SLOT_W     = 16;
    localparam int STAT_W     = 32;
    localparam int CAP_W      = 7;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SLOT = 1'd1;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd10;

    localparam logic MODE_ACQUIRE = 1'b0;
    localparam logic MODE_LOOKUP  = 1'b1;

    typedef struct packed {
        logic             mode;
        logic [KEY_W-1:0] key;
        logic             fetch_ok;
    } t_req;

    typedef struct packed {
        logic              hit;
        logic              fallback;
        logic [SLOT_W-1:0] slot_number;
        logic [STAT_W-1:0] total_fetches;
        logic [STAT_W-1:0] hit_count;
        logic [STAT_W-1:0] current_streak;
        logic [STAT_W-1:0] longest_streak;
    } t_res;

    typedef struct packed {
        logic upd;
        logic hit;
    } t_stat_evt;

    typedef struct packed {
        logic [STAT_W-1:0] total_fetches;
        logic [STAT_W-1:0] hit_count;
        logic [STAT_W-1:0] current_streak;
        logic [STAT_W-1:0] longest_streak;
    } t_stats;

endpackage

### sv/lcs_ram.sv
// ----------------------------------------------------------------------------
// lcs_ram
// Simple dual-port entry memory with one write port and a registered read.
// ----------------------------------------------------------------------------
module lcs_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 54
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

### sv/lcs_stats.sv
// ----------------------------------------------------------------------------
// lcs_stats
// Wrapping fetch, hit, current-streak and longest-streak counters.
// ----------------------------------------------------------------------------
module lcs_stats (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lcs_pkg::t_stat_evt i_evt,
    output lcs_pkg::t_stats    o_stats
);

    import lcs_pkg::*;

    logic [STAT_W-1:0] r_fetch;
    logic [STAT_W-1:0] r_hits;
    logic [STAT_W-1:0] r_streak;
    logic [STAT_W-1:0] r_best;
    logic [STAT_W-1:0] w_streak_inc;

    assign w_streak_inc = r_streak + STAT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fetch  <= '0;
            r_hits   <= '0;
            r_streak <= '0;
            r_best   <= '0;
        end else if (i_evt.upd) begin
            r_fetch <= r_fetch + STAT_W'(1);
            if (i_evt.hit) begin
                r_hits   <= r_hits + STAT_W'(1);
                r_streak <= w_streak_inc;
                if (w_streak_inc > r_best) begin
                    r_best <= w_streak_inc;
                end
            end else begin
                r_streak <= '0;
            end
        end
    end

    always_comb begin
        o_stats.total_fetches  = r_fetch;
        o_stats.hit_count      = r_hits;
        o_stats.current_streak = r_streak;
        o_stats.longest_streak = r_best;
    end

endmodule

### sv/lru_slot_cache_with_stats.sv
// ----------------------------------------------------------------------------
// lru_slot_cache_with_stats
// Fully associative LRU tag store mapping keys to slot numbers, with stats.
// ----------------------------------------------------------------------------
// The memory is scanned one word per cycle: once to search and, for a hit, an
// eviction or an insert into a free entry, once more to age; a lookup or a failed
// fetch is not aged. An empty store is not searched.
// A new word can be accepted at the edge that ends the result strobe; the
// receiver cannot stall. Reset empties the store, capacity 10, slot counter 0.
module lru_slot_cache_with_stats #(
    parameter int MAX_ENTRIES = 64,
    parameter int KEY_BITS    = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    input  lcs_pkg::t_req                      i_req,
    output logic                               busy,
    output logic                               o_valid,
    output lcs_pkg::t_res                      o_res,
    input  logic                               i_cfg_we,
    input  logic [lcs_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [lcs_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    import lcs_pkg::*;

    localparam int IDX_W  = $clog2(MAX_ENTRIES);
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int AGE_W  = IDX_W;
    localparam int WORD_W = KEY_BITS + SLOT_W + AGE_W;
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [SLOT_W-1:0]   slot;
        logic [AGE_W-1:0]    age;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_UPDATE
    } t_state;

    t_state              r_state;
    logic                r_mode;
    logic [KEY_BITS-1:0] r_key;
    logic                r_ok;
    logic [CNT_W-1:0]    r_ptr;
    logic                r_rd_vld;
    logic [IDX_W-1:0]    r_rd_idx;
    logic                r_found;
    logic [IDX_W-1:0]    r_hit_idx;
    logic [AGE_W-1:0]    r_hit_age;
    logic [SLOT_W-1:0]   r_hit_slot;
    logic                r_old_vld;
    logic [IDX_W-1:0]    r_old_idx;
    logic [AGE_W-1:0]    r_old_age;
    logic [SLOT_W-1:0]   r_old_slot;
    logic [CNT_W-1:0]    r_occ;
    logic [SLOT_W-1:0]   r_next_slot;
    logic [CAP_W-1:0]    r_capacity;
    logic [IDX_W-1:0]    r_dst;
    logic [IDX_W-1:0]    r_last;
    logic                r_all;
    logic [AGE_W-1:0]    r_limit;
    logic [SLOT_W-1:0]   r_new_slot;
    logic                r_res_hit;
    logic                r_res_fb;
    logic [SLOT_W-1:0]   r_res_slot;
    logic                r_strobe;

    logic                w_rd_en;
    logic [IDX_W-1:0]    w_rd_addr;
    logic [WORD_W-1:0]   w_rd_word;
    t_entry              w_rd_data;
    logic                w_wr_en;
    t_entry              w_wr_data;
    logic                w_scan_last;
    logic                w_upd_last;
    logic [CMP_W-1:0]    w_cap;
    logic [CMP_W-1:0]    w_eff;
    logic                w_full;
    logic [SLOT_W-1:0]   w_fresh;
    t_stat_evt           w_evt;
    t_stats              w_stats;

    lcs_ram #(
        .DEPTH (MAX_ENTRIES),
        .WIDTH (WORD_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_rd_idx),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_word)
    );

    lcs_stats u_stats (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (w_evt),
        .o_stats (w_stats)
    );

    assign w_rd_data = t_entry'(w_rd_word);
    assign w_rd_addr = r_ptr[IDX_W-1:0];
    assign w_rd_en   = ((r_state == S_SCAN) && (r_ptr < r_occ)) ||
                       ((r_state == S_UPDATE) && (r_ptr <= CNT_W'(r_last)));

    assign w_scan_last = r_rd_vld && ((CNT_W'(r_rd_idx) + CNT_W'(1)) == r_occ);
    assign w_upd_last  = r_rd_vld && (r_rd_idx == r_last);

    assign w_wr_en = (r_state == S_UPDATE) && r_rd_vld;

    always_comb begin
        w_wr_data = w_rd_data;
        if (r_rd_idx == r_dst) begin
            w_wr_data.key  = r_key;
            w_wr_data.slot = r_new_slot;
            w_wr_data.age  = '0;
        end else if (r_all || (w_rd_data.age < r_limit)) begin
            w_wr_data.age = w_rd_data.age + AGE_W'(1);
        end
    end

    assign w_cap   = CMP_W'(r_capacity);
    assign w_eff   = (w_cap == '0) ? CMP_W'(1) :
                     ((w_cap > CMP_W'(MAX_ENTRIES)) ? CMP_W'(MAX_ENTRIES) : w_cap);
    assign w_full  = CMP_W'(r_occ) >= w_eff;
    assign w_fresh = w_full ? r_old_slot : r_next_slot;

    assign w_evt.upd = (r_state == S_DECIDE) && (r_mode == MODE_ACQUIRE);
    assign w_evt.hit = r_found;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ptr       <= '0;
            r_rd_vld    <= 1'b0;
            r_occ       <= '0;
            r_next_slot <= '0;
            r_capacity  <= CAP_RESET;
            r_strobe    <= 1'b0;
            r_found     <= 1'b0;
            r_old_vld   <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            r_rd_vld <= w_rd_en;
            r_rd_idx <= w_rd_addr;
            if (w_rd_en) begin
                r_ptr <= r_ptr + CNT_W'(1);
            end
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_mode    <= i_req.mode;
                        r_key     <= KEY_BITS'(i_req.key);
                        r_ok      <= i_req.fetch_ok;
                        r_found   <= 1'b0;
                        r_old_vld <= 1'b0;
                        r_ptr     <= '0;
                        r_state   <= (r_occ == '0) ? S_DECIDE : S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_rd_vld) begin
                        if (w_rd_data.key == r_key) begin
                            r_found    <= 1'b1;
                            r_hit_idx  <= r_rd_idx;
                            r_hit_age  <= w_rd_data.age;
                            r_hit_slot <= w_rd_data.slot;
                        end
                        if (!r_old_vld || (w_rd_data.age > r_old_age)) begin
                            r_old_vld  <= 1'b1;
                            r_old_idx  <= r_rd_idx;
                            r_old_age  <= w_rd_data.age;
                            r_old_slot <= w_rd_data.slot;
                        end
                        if (w_scan_last) begin
                            r_state <= S_DECIDE;
                        end
                    end
                end
                S_DECIDE: begin
                    r_ptr <= '0;
                    if (r_mode == MODE_LOOKUP) begin
                        r_res_hit  <= r_found;
                        r_res_fb   <= !r_found;
                        r_res_slot <= r_found ? r_hit_slot : '0;
                        r_strobe   <= 1'b1;
                        r_state    <= S_IDLE;
                    end else if (r_found) begin
                        r_res_hit  <= 1'b1;
                        r_res_fb   <= 1'b0;
                        r_res_slot <= r_hit_slot;
                        r_dst      <= r_hit_idx;
                        r_last     <= IDX_W'(r_occ - CNT_W'(1));
                        r_all      <= 1'b0;
                        r_limit    <= r_hit_age;
                        r_new_slot <= r_hit_slot;
                        r_state    <= S_UPDATE;
                    end else begin
                        r_res_hit <= 1'b0;
                        if (!w_full) begin
                            r_next_slot <= r_next_slot + SLOT_W'(1);
                        end
                        if (!r_ok) begin
                            r_res_fb   <= 1'b1;
                            r_res_slot <= '0;
                            r_strobe   <= 1'b1;
                            r_state    <= S_IDLE;
                        end else begin
                            r_res_fb   <= 1'b0;
                            r_res_slot <= w_fresh;
                            r_new_slot <= w_fresh;
                            r_all      <= 1'b1;
                            r_limit    <= '0;
                            if (w_full) begin
                                r_dst  <= r_old_idx;
                                r_last <= IDX_W'(r_occ - CNT_W'(1));
                            end else begin
                                r_dst  <= r_occ[IDX_W-1:0];
                                r_last <= r_occ[IDX_W-1:0];
                                r_occ  <= r_occ + CNT_W'(1);
                            end
                            r_state <= S_UPDATE;
                        end
                    end
                end
                S_UPDATE: begin
                    if (w_upd_last) begin
                        r_strobe <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CAPACITY: begin
                        r_capacity <= i_cfg_data[CAP_W-1:0];
                    end
                    CFG_FIRST_SLOT: begin
                        r_next_slot <= i_cfg_data[SLOT_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_strobe;

    always_comb begin
        o_res.hit            = r_res_hit;
        o_res.fallback       = r_res_fb;
        o_res.slot_number    = r_res_slot;
        o_res.total_fetches  = w_stats.total_fetches;
        o_res.hit_count      = w_stats.hit_count;
        o_res.current_streak = w_stats.current_streak;
        o_res.longest_streak = w_stats.longest_streak;
    end

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CNT_W'(MAX_ENTRIES))
        else $error("entry count exceeds the store depth");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not make the block busy");

    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(busy) && !busy))
        else $error("result strobe without a finished request");

    a_fallback_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.fallback) |-> (o_res.slot_number == '0))
        else $error("fallback result carries a slot number");

    a_hit_no_fallback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.hit) |-> !o_res.fallback)
        else $error("hit result marked as fallback");

    a_write_in_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> (r_rd_idx <= r_last))
        else $error("entry write beyond the aging range");

endmodule
